// ===== src/crcwe_pkg.sv =====
// Shared types, register indexes and helper functions for the CRC-32 word engine.
package crcwe_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 3;
  localparam int unsigned IdxW   = 2;
  localparam int unsigned SweepW = $clog2(WordW + 1);

  localparam logic [WordW-1:0] PolyReset = 32'h04C1_1DB7;
  localparam logic [WordW-1:0] InitReset = 32'hFFFF_FFFF;
  localparam logic [WordW-1:0] MaskReset = 32'hFFFF_FFFF;
  localparam logic [WordW-1:0] CrcReset  = 32'hFFFF_FFFF;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [IdxW-1:0] {
    RegPolynomial = 2'd0,
    RegInitValue  = 2'd1,
    RegResultMask = 2'd2,
    RegUnused     = 2'd3
  } cfg_idx_e;

  // Column i holds x^(32+i) mod P: the effect of crc bit i after 32 steps.
  typedef struct packed {
    logic            ready;
    word_t [WordW-1:0] cols;
  } mat_t;

  // One MSB-first step of the CRC shift register.
  function automatic word_t poly_step(word_t value, word_t poly);
    word_t shifted;
    shifted = {value[WordW-2:0], 1'b0};
    return value[WordW-1] ? (shifted ^ poly) : shifted;
  endfunction

  // Place the valid bytes of a partial word at the top, zero the rest.
  function automatic word_t align_word(word_t word, logic [CountW-1:0] count);
    word_t res;
    res = word;
    case (count)
      3'd1:    res = {word[7:0], 24'h0};
      3'd2:    res = {word[15:0], 16'h0};
      3'd3:    res = {word[23:0], 8'h0};
      default: res = word;
    endcase
    return res;
  endfunction

endpackage

// ===== src/crcwe_matrix.sv =====
// Polynomial register and sweep that builds the 32 shift-matrix columns.
module crcwe_matrix (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  poly_we_i,
  input  crcwe_pkg::word_t      poly_i,
  output crcwe_pkg::mat_t       mat_o
);
  import crcwe_pkg::*;

  word_t             poly_q;
  word_t             cur_q, cur_d;
  word_t [WordW-1:0] cols_q, cols_d;
  logic [SweepW-1:0] cnt_q, cnt_d;

  always_comb begin
    cur_d  = cur_q;
    cols_d = cols_q;
    cnt_d  = cnt_q;
    if (cnt_q != '0) begin
      // advance: shift the columns down, append the next power of x
      for (int k = 0; k < WordW - 1; k++) begin
        cols_d[k] = cols_q[k+1];
      end
      cols_d[WordW-1] = cur_q;
      cur_d = poly_step(cur_q, poly_q);
      cnt_d = cnt_q - 1'b1;
    end
    if (poly_we_i) begin
      cur_d = poly_i;
      cnt_d = SweepW'(WordW);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= PolyReset;
      cur_q  <= PolyReset;
      cnt_q  <= SweepW'(WordW);
    end else begin
      if (poly_we_i) begin
        poly_q <= poly_i;
      end
      cur_q <= cur_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cols_q <= cols_d;
  end

  assign mat_o.ready = (cnt_q == '0);
  assign mat_o.cols  = cols_q;

`ifndef ASSERT_OFF
  a_write_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    poly_we_i |=> !mat_o.ready && cnt_q == SweepW'(WordW))
    else $error("poly write did not restart the sweep");
  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= SweepW'(WordW))
    else $error("sweep count out of range");
  a_cur_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0 && !poly_we_i) |=> cols_q[WordW-1] == $past(cur_q))
    else $error("column shift lost the current power");
`endif

endmodule

// ===== src/crcwe_core.sv =====
// Input register, one-pass CRC update and output register.
module crcwe_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  crcwe_pkg::word_t             data_word_i,
  input  logic [crcwe_pkg::CountW-1:0] valid_bytes_i,
  input  logic                         start_req_i,
  input  crcwe_pkg::mat_t              mat_i,
  input  crcwe_pkg::word_t             init_value_i,
  input  crcwe_pkg::word_t             result_mask_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output crcwe_pkg::word_t             crc_value_o
);
  import crcwe_pkg::*;

  logic              s1_valid_q;
  word_t             s1_word_q;
  logic [CountW-1:0] s1_count_q;
  logic              s1_start_q;
  logic              s1_adv;
  logic              in_xfer;
  word_t             crc_q, crc_d;
  logic              out_valid_q;
  word_t             out_crc_q;
  word_t             base;
  word_t             mixed;
  word_t             shifted;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = mat_i.ready && (!s1_valid_q || s1_adv);
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    base    = s1_start_q ? init_value_i : crc_q;
    mixed   = base ^ align_word(s1_word_q, s1_count_q);
    shifted = '0;
    for (int i = 0; i < WordW; i++) begin
      if (mixed[i]) begin
        shifted = shifted ^ mat_i.cols[i];
      end
    end
    // a word with no valid bytes only reloads or holds the CRC
    crc_d = (s1_count_q == '0) ? base : (shifted & result_mask_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      crc_q       <= CrcReset;
    end else begin
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
        crc_q       <= crc_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_word_q  <= data_word_i;
      s1_count_q <= valid_bytes_i;
      s1_start_q <= start_req_i;
    end
    if (s1_adv) begin
      out_crc_q <= crc_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign crc_value_o = out_crc_q;

`ifndef ASSERT_OFF
  a_no_take_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !mat_i.ready |-> !in_ready_o)
    else $error("input taken while matrix is rebuilt");
  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q && out_crc_q == crc_q)
    else $error("advanced item did not reach the output register");
  a_stall_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> $stable(crc_q))
    else $error("running CRC moved during an output stall");
`endif

endmodule

// ===== src/crc32_word_engine.sv =====
// Top level of the CRC-32 word engine: configuration registers and submodules.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one buffer word per transfer:
//   data_word_i (first byte in bits 7:0), valid_bytes_i (1..4, partial words
//   are aligned to the top) and start_req_i (load initial_value first).
//   Output channel (out_valid_o/out_ready_i) returns the masked running CRC
//   for every word, in order.
//   An accepted word goes from the input register to the output register
//   (out_valid_o). Throughput is one word per cycle while out_ready_i is
//   high and no column build runs, set by the single XOR-matrix pass
//   between the input and output registers that also updates the running CRC.
//   A stalled receiver holds the output register; one more word waits in the
//   input register, then in_ready_o drops until the output drains.
//   Configuration: wr_en_i/wr_idx_i/wr_data_i write polynomial (0),
//   initial_value (1) and result_mask (2). A polynomial write rebuilds
//   the 32 matrix columns, with in_ready_o low while the build runs.
//   Reset loads the default registers, sets the CRC to all ones and runs the
//   same column build before the first word is taken.
module crc32_word_engine (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         wr_en_i,
  input  logic [crcwe_pkg::IdxW-1:0]   wr_idx_i,
  input  logic [crcwe_pkg::WordW-1:0]  wr_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [crcwe_pkg::WordW-1:0]  data_word_i,
  input  logic [crcwe_pkg::CountW-1:0] valid_bytes_i,
  input  logic                         start_req_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [crcwe_pkg::WordW-1:0]  crc_value_o
);
  import crcwe_pkg::*;

  word_t init_value_q;
  word_t result_mask_q;
  logic  poly_we;
  mat_t  mat;

  assign poly_we = wr_en_i && (wr_idx_i == RegPolynomial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_value_q  <= InitReset;
      result_mask_q <= MaskReset;
    end else if (wr_en_i) begin
      case (cfg_idx_e'(wr_idx_i))
        RegInitValue:  init_value_q  <= wr_data_i;
        RegResultMask: result_mask_q <= wr_data_i;
        default: ;
      endcase
    end
  end

  crcwe_matrix u_matrix (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .poly_we_i (poly_we),
    .poly_i    (wr_data_i),
    .mat_o     (mat)
  );

  crcwe_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_word_i   (data_word_i),
    .valid_bytes_i (valid_bytes_i),
    .start_req_i   (start_req_i),
    .mat_i         (mat),
    .init_value_i  (init_value_q),
    .result_mask_i (result_mask_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .crc_value_o   (crc_value_o)
  );

endmodule

// ===== tb/sv/crc32_word_engine_tb.sv =====
// Self-checking testbench for the CRC-32 word engine: directed and random word streams.
`timescale 1ns / 1ps

module crc32_word_engine_tb;
  import crcwe_pkg::*;

  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned RandPhases  = 12;
  localparam int unsigned PhaseWords  = 160;
  localparam int unsigned PrintLimit  = 20;

  typedef struct packed {
    word_t             data;
    logic [CountW-1:0] nbytes;
    logic              start;
  } word_item_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              wr_en_i       = 1'b0;
  logic [IdxW-1:0]   wr_idx_i      = '0;
  word_t             wr_data_i     = '0;
  logic              in_valid_i    = 1'b0;
  logic              in_ready_o;
  word_t             data_word_i   = '0;
  logic [CountW-1:0] valid_bytes_i = '0;
  logic              start_req_i   = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i   = 1'b0;
  word_t             crc_value_o;

  word_item_t  word_queue[$];
  word_t       crc_expected[$];

  // Predictor copy of the configuration and the running CRC.
  word_t       poly_reg;
  word_t       init_reg;
  word_t       mask_reg;
  word_t       crc_state;

  int unsigned send_gap;
  int unsigned stall_left;
  int unsigned idle_cycles;
  int unsigned error_count;
  int unsigned words_in;
  int unsigned crcs_out;
  int unsigned start_words;
  int unsigned short_words;
  int unsigned empty_words;
  int unsigned wide_words;
  int unsigned reg_writes;
  bit          calm;

  word_item_t  next_word;
  logic        next_valid;
  word_t       want_crc;

  crc32_word_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .wr_en_i       (wr_en_i),
    .wr_idx_i      (wr_idx_i),
    .wr_data_i     (wr_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_word_i   (data_word_i),
    .valid_bytes_i (valid_bytes_i),
    .start_req_i   (start_req_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .crc_value_o   (crc_value_o)
  );

  always #5 clk_i = ~clk_i;

  // Fold one word into the predicted CRC and return the new value.
  function automatic word_t crc_advance(word_item_t item);
    logic [CountW-1:0] n;
    word_t             folded;
    int                k;
    if (item.start) crc_state = init_reg;
    n = (item.nbytes > 3'd4) ? 3'd4 : item.nbytes;
    if (n != 3'd0) begin
      folded = item.data;
      // Partial word: keep the low bytes and move them to the top.
      if (n < 3'd4) folded = (item.data & ((32'h1 << (8 * n)) - 32'h1)) << (8 * (4 - n));
      crc_state = crc_state ^ folded;
      for (k = 0; k < 32; k++) begin
        crc_state = crc_state[WordW-1] ? ((crc_state << 1) ^ poly_reg) : (crc_state << 1);
      end
      crc_state = crc_state & mask_reg;
    end
    return crc_state;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic word_t pick_data();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  function automatic word_t pick_reg_value(word_t dflt);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return dflt;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_error(string msg);
    error_count++;
    if (error_count <= PrintLimit) $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  task automatic push_word(word_t data, logic [CountW-1:0] nbytes, logic start);
    word_item_t item;
    item.data   = data;
    item.nbytes = nbytes;
    item.start  = start;
    word_queue.push_back(item);
  endtask

  // Well-formed buffer: start on the first word, full words, then a 1..4 byte tail.
  task automatic queue_message(int unsigned len);
    int unsigned k;
    for (k = 0; k < len; k++) begin
      push_word(pick_data(), (k == len - 1) ? 3'($urandom_range(1, 4)) : 3'd4, k == 0);
    end
  endtask

  task automatic queue_noise();
    push_word(pick_data(), 3'($urandom_range(0, 7)), $urandom_range(0, 3) == 0);
  endtask

  // Hold until every queued word is transferred and every CRC has come back.
  task automatic drain();
    @(negedge clk_i);
    while (word_queue.size() != 0 || in_valid_i || crc_expected.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic write_reg(cfg_idx_e idx, word_t value);
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    wr_en_i   <= 1'b1;
    wr_idx_i  <= idx;
    wr_data_i <= value;
    case (idx)
      RegPolynomial: poly_reg = value;
      RegInitValue:  init_reg = value;
      RegResultMask: mask_reg = value;
      default:       ;
    endcase
    reg_writes++;
    @(posedge clk_i);
    wr_en_i <= 1'b0;
  endtask

  // Driver: present queued words, predict on each input transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else begin
      next_valid = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        next_word.data   = data_word_i;
        next_word.nbytes = valid_bytes_i;
        next_word.start  = start_req_i;
        crc_expected.push_back(crc_advance(next_word));
        words_in++;
        if (start_req_i) start_words++;
        if (valid_bytes_i == 3'd0) empty_words++;
        else if (valid_bytes_i < 3'd4) short_words++;
        else if (valid_bytes_i > 3'd4) wide_words++;
        next_valid = 1'b0;
        send_gap = pick_gap();
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (word_queue.size() != 0) begin
          next_word = word_queue.pop_front();
          data_word_i   <= next_word.data;
          valid_bytes_i <= next_word.nbytes;
          start_req_i   <= next_word.start;
          next_valid = 1'b1;
        end
      end
      in_valid_i <= next_valid;
    end
  end

  // Monitor: check each output transfer against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        crcs_out++;
        if (crc_expected.size() == 0) begin
          report_error($sformatf("crc %h with no word outstanding", crc_value_o));
        end else begin
          want_crc = crc_expected.pop_front();
          if (crc_value_o !== want_crc) begin
            report_error($sformatf("crc_value %h, predicted %h (result %0d)",
                                   crc_value_o, want_crc, crcs_out));
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("timeout: no transfer for %0d cycles", StallLimit);
        $display("crc32_word_engine verification failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned phase;
    int unsigned target;
    poly_reg  = PolyReset;
    init_reg  = InitReset;
    mask_reg  = MaskReset;
    crc_state = CrcReset;
    calm      = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset configuration: first word runs from the reset CRC without a start.
    @(negedge clk_i);
    push_word(32'h0000_0000, 3'd4, 1'b0);
    push_word(32'h3433_3231, 3'd4, 1'b1);
    push_word(32'h3837_3635, 3'd4, 1'b0);
    push_word(32'hAABB_CC39, 3'd1, 1'b0);
    push_word(32'hFFFF_FFFF, 3'd4, 1'b1);
    push_word(32'h1234_5678, 3'd2, 1'b0);
    push_word(32'hDEAD_BEEF, 3'd3, 1'b0);
    push_word(32'h0BAD_F00D, 3'd0, 1'b0);
    push_word(32'h5555_5555, 3'd0, 1'b1);
    push_word(32'hAAAA_AAAA, 3'd5, 1'b0);
    push_word(32'h1357_9BDF, 3'd6, 1'b1);
    push_word(32'hFFFF_FFFF, 3'd7, 1'b0);
    push_word(32'hFFFF_FFFF, 3'd1, 1'b0);
    drain();

    // All-zero registers.
    write_reg(RegResultMask, 32'h0000_0000);
    write_reg(RegInitValue, 32'h0000_0000);
    write_reg(RegPolynomial, 32'h0000_0000);
    @(negedge clk_i);
    push_word(32'h0123_4567, 3'd4, 1'b1);
    push_word(32'h89AB_CDEF, 3'd3, 1'b0);
    push_word(32'h0000_0000, 3'd0, 1'b1);
    drain();

    // All-ones initial value and polynomial, narrow mask, and a write to the spare index.
    write_reg(RegInitValue, 32'hFFFF_FFFF);
    write_reg(RegResultMask, 32'h0000_FFFF);
    write_reg(RegUnused, $urandom);
    write_reg(RegPolynomial, 32'hFFFF_FFFF);
    @(negedge clk_i);
    push_word(32'hFFFF_FFFF, 3'd4, 1'b1);
    push_word(32'h8000_0000, 3'd4, 1'b0);
    push_word(32'h0000_0001, 3'd1, 1'b0);
    push_word(32'h7FFF_FFFF, 3'd2, 1'b1);
    drain();

    for (phase = 0; phase < RandPhases; phase++) begin
      if ($urandom_range(0, 2) != 0) write_reg(RegInitValue, pick_reg_value(InitReset));
      // Mostly full masks so the CRC keeps its entropy.
      if ($urandom_range(0, 2) != 0) begin
        write_reg(RegResultMask, ($urandom_range(0, 1) == 0) ? MaskReset : pick_reg_value(MaskReset));
      end
      if ($urandom_range(0, 5) == 0) write_reg(RegUnused, $urandom);
      if ($urandom_range(0, 2) != 0) write_reg(RegPolynomial, pick_reg_value(PolyReset));
      @(negedge clk_i);
      calm   = (phase % 4 == 3);
      target = word_queue.size() + PhaseWords;
      while (word_queue.size() < target) begin
        if ($urandom_range(0, 9) == 0) queue_noise();
        else if ($urandom_range(0, 7) == 0) queue_message($urandom_range(5, 24));
        else queue_message($urandom_range(1, 4));
      end
      drain();
    end

    calm = 1'b0;
    repeat (DrainCycles) @(posedge clk_i);
    if (crc_expected.size() != 0) begin
      report_error($sformatf("%0d predicted crcs never returned", crc_expected.size()));
    end
    $display("covered %0d words (%0d start, %0d partial, %0d empty, %0d oversized), %0d crcs",
             words_in, start_words, short_words, empty_words, wide_words, crcs_out);
    $display("register writes: %0d, mismatches: %0d", reg_writes, error_count);
    if (error_count == 0) begin
      $display("crc32_word_engine verification clean");
    end else begin
      $display("crc32_word_engine verification failed");
    end
    $finish;
  end

endmodule
